### rtl/abf_pkg.sv
// Package for the adaptive Bezier flattener: item structs and shared constants.
// Used by adaptive_bezier_flattener_top and its testbench. No dependencies.
package abf_pkg;

  localparam int CW = 24;

  localparam logic FUNC_CUBIC = 1'b0;
  localparam logic FUNC_QUAD  = 1'b1;

  localparam logic [0:0] REG_TOLERANCE   = 1'd0;
  localparam logic [0:0] REG_DEPTH_LIMIT = 1'd1;

  typedef struct packed {
    logic                 func;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] ctrl1_x;
    logic signed [CW-1:0] ctrl1_y;
    logic signed [CW-1:0] ctrl2_x;
    logic signed [CW-1:0] ctrl2_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } curve_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 last_point;
  } point_t;

endpackage

### rtl/abf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module abf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/adaptive_bezier_flattener_top.sv
// Adaptive Bezier flattener top level: sequencer, shared multiplier, piece stack.
// Depends on abf_pkg and abf_ram.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall   | abf_pkg::curve_t
//  out     | output    | out_valid/out_stall | abf_pkg::point_t
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Each subdivision test runs on the one shared 34x34 multiplier (four cross products,
// two squares, tolerance squared, three limb products of the square, then two
// products with tolerance squared); a split passes through S_SPLIT1 to S_SPLIT3, an
// emit through S_EMIT and a stack pop through S_POP and S_POP2. Reset is synchronous;
// the stack needs no clearing pass.
// The output register holds a point while out_stall is high, and the sequencer
// waits at its next emit until that point has gone.
module adaptive_bezier_flattener_top #(
  parameter int MAX_DEPTH = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  abf_pkg::curve_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output abf_pkg::point_t  out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import abf_pkg::*;

  localparam int PIECES = MAX_DEPTH + 1;
  localparam int SAW    = $clog2(PIECES + 1);
  localparam int SIW    = $clog2(PIECES);
  localparam int LVW    = $clog2(MAX_DEPTH + 1);
  localparam int MAXOUT = 1 << MAX_DEPTH;
  localparam int NW     = $clog2(MAXOUT + 1);
  // Differences need CW+1 bits; products are 2CW+2; sums grow a bit more.
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW + 2;
  localparam int MW  = 34;
  localparam int SQW = 2 * PW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_TEST   = 5'd1;
  localparam logic [4:0] S_M1     = 5'd2;
  localparam logic [4:0] S_M2     = 5'd3;
  localparam logic [4:0] S_M3     = 5'd4;
  localparam logic [4:0] S_M4     = 5'd5;
  localparam logic [4:0] S_M5     = 5'd6;
  localparam logic [4:0] S_M6     = 5'd7;
  localparam logic [4:0] S_SQ0    = 5'd8;
  localparam logic [4:0] S_SQ1    = 5'd9;
  localparam logic [4:0] S_SQ2    = 5'd10;
  localparam logic [4:0] S_SQ3    = 5'd11;
  localparam logic [4:0] S_T0     = 5'd12;
  localparam logic [4:0] S_T1     = 5'd13;
  localparam logic [4:0] S_T2     = 5'd14;
  localparam logic [4:0] S_CMP    = 5'd15;
  localparam logic [4:0] S_SPLIT1 = 5'd16;
  localparam logic [4:0] S_SPLIT2 = 5'd17;
  localparam logic [4:0] S_SPLIT3 = 5'd18;
  localparam logic [4:0] S_EMIT   = 5'd19;
  localparam logic [4:0] S_POP    = 5'd20;
  localparam logic [4:0] S_POP2   = 5'd21;

  logic [4:0] state;
  logic [15:0] tolerance;
  logic [2:0] depth_limit;

  logic cubic;
  logic signed [CW-1:0] p [8];
  logic [LVW-1:0] level;
  logic [SAW-1:0] stack_top;
  logic [NW-1:0]  n_out;

  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] acc_d1, acc_d2, chord;
  logic signed [2*MW-1:0] prod_a;
  logic [PW-1:0] s_abs;
  logic [SQW-1:0] s_sq;
  logic [31:0] tol_sq;
  logic [PW+32-1:0] rhs;

  // Shared multiplier, one product per cycle with a register after it.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] mul_q;
  assign mul_q = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_a <= mul_q;
  end

  // Stack: one RAM row holds the eight coordinates and the level of a piece.
  localparam int RW = 8 * CW + LVW;
  logic           st_we;
  logic [SIW-1:0] st_waddr, st_raddr;
  logic [RW-1:0]  st_wdata, st_rdata;

  abf_ram #(.WIDTH(RW), .DEPTH(PIECES)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  function automatic logic signed [CW-1:0] midp(logic signed [CW-1:0] a,
                                                 logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = CW'(0) + {a[CW-1], a} + {b[CW-1], b};
    return s[CW:1];
  endfunction

  // Endpoint index: 6 for cubic, 4 for quadratic.
  logic signed [CW-1:0] ex_x, ex_y;
  assign ex_x = cubic ? p[6] : p[4];
  assign ex_y = cubic ? p[7] : p[5];

  logic [2:0] limit;
  assign limit = (depth_limit > 3'(MAX_DEPTH)) ? 3'(MAX_DEPTH) : depth_limit;

  logic zero_chord;
  assign zero_chord = (ex_x == p[0]) && (ex_y == p[1]);

  // Split midpoints computed from registered coordinates over three steps.
  logic signed [CW-1:0] x01, y01, x12, y12, x23, y23, xa, ya, xb, yb;

  logic signed [DW-1:0] cdx, cdy;
  always_comb begin
    cdx = '0;
    cdy = '0;
    case (state)
      S_M1, S_M2: begin
        cdx = DW'(p[2]) - DW'(ex_x);
        cdy = DW'(p[3]) - DW'(ex_y);
      end
      default: begin
        cdx = DW'(p[4]) - DW'(p[6]);
        cdy = DW'(p[5]) - DW'(p[7]);
      end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin mul_a = MW'(cdx); mul_b = MW'(dy); end
      S_M2: begin mul_a = MW'(cdy); mul_b = MW'(dx); end
      S_M3: begin mul_a = MW'(cdx); mul_b = MW'(dy); end
      S_M4: begin mul_a = MW'(cdy); mul_b = MW'(dx); end
      S_M5: begin mul_a = MW'(dx);  mul_b = MW'(dx); end
      S_M6: begin mul_a = MW'(dy);  mul_b = MW'(dy); end
      S_SQ0: begin
        mul_a = MW'({1'b0, tolerance});
        mul_b = MW'({1'b0, tolerance});
      end
      // s squared from 26-bit halves: lo*lo, lo*hi, hi*hi.
      S_SQ1: begin mul_a = MW'({1'b0, s_abs[25:0]}); mul_b = MW'({1'b0, s_abs[25:0]}); end
      S_SQ2: begin mul_a = MW'({1'b0, s_abs[25:0]}); mul_b = MW'({1'b0, s_abs[PW-1:26]}); end
      S_SQ3: begin
        mul_a = MW'({1'b0, s_abs[PW-1:26]});
        mul_b = MW'({1'b0, s_abs[PW-1:26]});
      end
      // rhs = tol_sq * chord from 26-bit halves of chord.
      S_T0: begin mul_a = MW'({1'b0, tol_sq}); mul_b = MW'({1'b0, chord[25:0]}); end
      S_T1: begin mul_a = MW'({1'b0, tol_sq}); mul_b = MW'({1'b0, chord[PW-1:26]}); end
      default: ;
    endcase
  end

  logic [PW-1:0] d_abs;
  assign d_abs = acc_d1[PW-1] ? PW'(-acc_d1) : PW'(acc_d1);

  logic [PW-1:0] d2_abs;
  assign d2_abs = acc_d2[PW-1] ? PW'(-acc_d2) : PW'(acc_d2);

  logic [SQW-1:0] prod_u;
  assign prod_u = SQW'(unsigned'(prod_a));

  always_comb begin
    st_we    = 1'b0;
    st_waddr = stack_top[SIW-1:0];
    st_raddr = SIW'(stack_top - SAW'(1));
    st_wdata = '0;
    if (state == S_SPLIT3) begin
      st_we = 1'b1;
      if (cubic) begin
        st_wdata = {midp(xa, xb), midp(ya, yb), xb, yb, x23, y23, p[6], p[7],
                    LVW'(level + LVW'(1))};
      end else begin
        st_wdata = {midp(x01, x12), midp(y01, y12), x12, y12, p[4], p[5],
                    CW'(0), CW'(0), LVW'(level + LVW'(1))};
      end
    end
  end

  logic emit_last;
  assign emit_last = (stack_top == '0) || (n_out >= NW'(MAXOUT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tolerance   <= 16'd64;
      depth_limit <= 3'd6;
      out_valid   <= 1'b0;
      stack_top   <= '0;
      n_out       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOLERANCE:   tolerance   <= cfg_data;
          REG_DEPTH_LIMIT: depth_limit <= cfg_data[2:0];
          default: ;
        endcase
      end
      // The emit state either reloads the output register or holds it.
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cubic <= (in_data.func == FUNC_CUBIC);
            p[0] <= in_data.start_x; p[1] <= in_data.start_y;
            p[2] <= in_data.ctrl1_x; p[3] <= in_data.ctrl1_y;
            if (in_data.func == FUNC_CUBIC) begin
              p[4] <= in_data.ctrl2_x; p[5] <= in_data.ctrl2_y;
              p[6] <= in_data.end_x;   p[7] <= in_data.end_y;
            end else begin
              p[4] <= in_data.end_x; p[5] <= in_data.end_y;
              p[6] <= '0;            p[7] <= '0;
            end
            level     <= '0;
            stack_top <= '0;
            n_out     <= '0;
            state     <= S_TEST;
          end
        end
        S_TEST: begin
          dx <= DW'(ex_x) - DW'(p[0]);
          dy <= DW'(ex_y) - DW'(p[1]);
          if (zero_chord || (3'(level) >= limit) || (stack_top >= SAW'(PIECES))) begin
            state <= S_EMIT;
          end else begin
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin acc_d1 <= PW'(prod_a); state <= S_M3; end
        S_M3: begin acc_d1 <= acc_d1 - PW'(prod_a); state <= S_M4; end
        S_M4: begin acc_d2 <= PW'(prod_a); state <= S_M5; end
        S_M5: begin acc_d2 <= acc_d2 - PW'(prod_a); state <= S_M6; end
        S_M6: begin
          chord <= PW'(prod_a);
          s_abs <= d_abs + (cubic ? d2_abs : '0);
          state <= S_SQ0;
        end
        S_SQ0: begin chord <= chord + PW'(prod_a); state <= S_SQ1; end
        S_SQ1: begin tol_sq <= 32'(prod_a); state <= S_SQ2; end
        S_SQ2: begin s_sq <= prod_u; state <= S_SQ3; end
        S_SQ3: begin s_sq <= s_sq + (prod_u << 27); state <= S_T0; end
        S_T0: begin s_sq <= s_sq + (prod_u << 52); state <= S_T1; end
        S_T1: begin rhs <= (PW+32)'(prod_u); state <= S_T2; end
        S_T2: begin rhs <= rhs + ((PW+32)'(prod_u) << 26); state <= S_CMP; end
        S_CMP: begin
          if (s_sq <= SQW'(rhs)) state <= S_EMIT;
          else state <= S_SPLIT1;
        end
        S_SPLIT1: begin
          x01 <= midp(p[0], p[2]); y01 <= midp(p[1], p[3]);
          x12 <= midp(p[2], p[4]); y12 <= midp(p[3], p[5]);
          x23 <= midp(p[4], p[6]); y23 <= midp(p[5], p[7]);
          state <= S_SPLIT2;
        end
        S_SPLIT2: begin
          xa <= midp(x01, x12); ya <= midp(y01, y12);
          xb <= midp(x12, x23); yb <= midp(y12, y23);
          state <= S_SPLIT3;
        end
        S_SPLIT3: begin
          p[2] <= x01; p[3] <= y01;
          if (cubic) begin
            p[4] <= xa; p[5] <= ya;
            p[6] <= midp(xa, xb); p[7] <= midp(ya, yb);
          end else begin
            p[4] <= midp(x01, x12); p[5] <= midp(y01, y12);
          end
          level     <= LVW'(level + LVW'(1));
          stack_top <= stack_top + SAW'(1);
          state     <= S_TEST;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_data.point_x    <= ex_x;
            out_data.point_y    <= ex_y;
            out_data.last_point <= emit_last;
            n_out               <= n_out + NW'(1);
            state               <= emit_last ? S_IDLE : S_POP;
          end
        end
        S_POP: begin
          stack_top <= stack_top - SAW'(1);
          state     <= S_POP2;
        end
        S_POP2: begin
          {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], level} <= st_rdata;
          state <= S_TEST;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  // The stack never holds more pieces than it has rows.
  assert property (@(posedge clk) disable iff (rst) stack_top <= SAW'(PIECES))
    else $error("stack overflow");

  // A point is only loaded while the sequencer emits.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("output loaded outside emit");

  // Every curve finishes with an empty stack or with the output count at its cap.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_last && !(out_valid && out_stall)) |-> stack_top == '0
      || n_out >= NW'(MAXOUT - 1))
    else $error("last point with pending pieces");

endmodule

### test/tb_adaptive_bezier_flattener_top.sv
// Testbench for the adaptive Bezier flattener: drives curves, predicts the emitted
// polyline vertices and compares them. Depends on abf_pkg and adaptive_bezier_flattener_top.
`timescale 1ns / 1ps

class polyline_scoreboard;
  abf_pkg::point_t pending_points[$];
  int unsigned failures;
  logic [15:0] tol;
  logic [2:0] depth_cap;

  function new();
    failures = 0;
    tol = 16'd64;
    depth_cap = 3'd6;
  endfunction

  // Midpoint as an arithmetic shift of the exact sum, so it rounds down.
  function automatic longint halve(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  // Absolute cross product of (c - e) with the chord.
  function automatic logic [127:0] deviation(longint cx, longint cy, longint ex, longint ey,
                                             longint dx, longint dy);
    logic signed [127:0] p;
    p = 128'(cx - ex) * 128'(dy) - 128'(cy - ey) * 128'(dx);
    if (p < 0) p = -p;
    return p;
  endfunction

  function automatic bit is_flat(longint pc[8], bit cubic, int ei);
    longint dx, dy;
    logic [255:0] s, chord, lhs, rhs;
    dx = pc[ei] - pc[0];
    dy = pc[ei+1] - pc[1];
    s = 256'(deviation(pc[2], pc[3], pc[ei], pc[ei+1], dx, dy));
    if (cubic) s = s + 256'(deviation(pc[4], pc[5], pc[6], pc[7], dx, dy));
    chord = 256'(dx * dx) + 256'(dy * dy);
    lhs = s * s;
    rhs = 256'(tol) * 256'(tol) * chord;
    return lhs <= rhs;
  endfunction

  function void note_curve(abf_pkg::curve_t c);
    longint cur[8];
    longint stk[7][8];
    int lvl_stk[7];
    int top, lvl, n, ei, lim;
    bit cubic;
    abf_pkg::point_t pt;
    longint x01, y01, x12, y12, x23, y23, xa, ya, xb, yb, xc, yc;
    cubic = (c.func == abf_pkg::FUNC_CUBIC);
    ei = cubic ? 6 : 4;
    lim = (depth_cap > 6) ? 6 : depth_cap;
    cur[0] = c.start_x; cur[1] = c.start_y; cur[2] = c.ctrl1_x; cur[3] = c.ctrl1_y;
    if (cubic) begin
      cur[4] = c.ctrl2_x; cur[5] = c.ctrl2_y; cur[6] = c.end_x; cur[7] = c.end_y;
    end else begin
      cur[4] = c.end_x; cur[5] = c.end_y; cur[6] = 0; cur[7] = 0;
    end
    top = 0; lvl = 0; n = 0;
    forever begin
      if ((cur[ei] == cur[0] && cur[ei+1] == cur[1]) || lvl >= lim || top >= 7 ||
          is_flat(cur, cubic, ei)) begin
        pt.point_x = 24'(cur[ei]);
        pt.point_y = 24'(cur[ei+1]);
        pt.last_point = (top == 0 || n >= 63);
        pending_points.push_back(pt);
        n++;
        if (top == 0 || n >= 64) break;
        top--;
        cur = stk[top];
        lvl = lvl_stk[top];
      end else begin
        x01 = halve(cur[0], cur[2]); y01 = halve(cur[1], cur[3]);
        x12 = halve(cur[2], cur[4]); y12 = halve(cur[3], cur[5]);
        if (cubic) begin
          x23 = halve(cur[4], cur[6]); y23 = halve(cur[5], cur[7]);
          xa = halve(x01, x12); ya = halve(y01, y12);
          xb = halve(x12, x23); yb = halve(y12, y23);
          xc = halve(xa, xb); yc = halve(ya, yb);
          stk[top] = '{xc, yc, xb, yb, x23, y23, cur[6], cur[7]};
          cur[2] = x01; cur[3] = y01; cur[4] = xa; cur[5] = ya; cur[6] = xc; cur[7] = yc;
        end else begin
          xc = halve(x01, x12); yc = halve(y01, y12);
          stk[top] = '{xc, yc, x12, y12, cur[4], cur[5], 0, 0};
          cur[2] = x01; cur[3] = y01; cur[4] = xc; cur[5] = yc;
        end
        lvl++;
        lvl_stk[top] = lvl;
        top++;
      end
    end
  endfunction

  function void check_point(abf_pkg::point_t got);
    abf_pkg::point_t exp_pt;
    if (pending_points.size() == 0) begin
      $error("unexpected point x=%0d y=%0d", got.point_x, got.point_y);
      failures++;
      return;
    end
    exp_pt = pending_points.pop_front();
    if (got.point_x !== exp_pt.point_x) begin
      $error("point_x: expected %0d, got %0d", exp_pt.point_x, got.point_x);
      failures++;
    end
    if (got.point_y !== exp_pt.point_y) begin
      $error("point_y: expected %0d, got %0d", exp_pt.point_y, got.point_y);
      failures++;
    end
    if (got.last_point !== exp_pt.last_point) begin
      $error("last_point: expected %0d, got %0d", exp_pt.last_point, got.last_point);
      failures++;
    end
  endfunction
endclass

module tb_adaptive_bezier_flattener_top;
  import abf_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  curve_t in_data;
  point_t out_data;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;

  int send_idle_pct, recv_stall_pct;
  int unsigned quiet_cycles;
  polyline_scoreboard board;

  adaptive_bezier_flattener_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_TOLERANCE; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
  end

  // Receiver: random stall, check accepted points.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_point(out_data);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The block stalls its input while it works on an item, so the extra edge costs nothing.
  task automatic send_curve(curve_t c);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    board.note_curve(c);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TOLERANCE) board.tol = val;
    else board.depth_cap = val[2:0];
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] rcoord(int spread);
    case ($urandom_range(3))
      0: return 24'($urandom);
      default: return 24'($signed($urandom_range(2 * spread)) - spread);
    endcase
  endfunction

  function automatic curve_t rand_curve();
    curve_t c;
    int sp;
    sp = ($urandom_range(1)) ? 4096 : 400000;
    c.func = 1'($urandom_range(1));
    c.start_x = rcoord(sp); c.start_y = rcoord(sp);
    c.ctrl1_x = rcoord(sp); c.ctrl1_y = rcoord(sp);
    c.ctrl2_x = rcoord(sp); c.ctrl2_y = rcoord(sp);
    c.end_x = rcoord(sp); c.end_y = rcoord(sp);
    if ($urandom_range(15) == 0) begin
      c.end_x = c.start_x; c.end_y = c.start_y;
    end
    return c;
  endfunction

  function automatic curve_t mk(logic f, int sx, int sy, int ax, int ay, int bx, int by,
                                int ex, int ey);
    curve_t c;
    c = '{f, 24'(sx), 24'(sy), 24'(ax), 24'(ay), 24'(bx), 24'(by), 24'(ex), 24'(ey)};
    return c;
  endfunction

  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed curves at reset settings.
    send_curve(mk(FUNC_CUBIC, 0, 0, 2560, 5120, 7680, 5120, 10240, 0));
    send_curve(mk(FUNC_QUAD, 0, 0, 2560, 5120, 0, 0, 5120, 0));
    send_curve(mk(FUNC_CUBIC, 100, 100, 9000, -3000, 4, 4, 100, 100));
    send_curve(mk(FUNC_QUAD, MINC, MINC, MAXC, MAXC, 0, 0, MAXC, MINC));
    send_curve(mk(FUNC_CUBIC, MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC));
    send_curve(mk(FUNC_CUBIC, 0, 0, 256, 256, 512, 512, 768, 768));
    send_curve(mk(FUNC_QUAD, -1, -1, -1, -1, 7, 7, -1, -1));
    send_curve(mk(FUNC_QUAD, 0, 0, MAXC, MINC, 55, 66, 1000, 0));
    drain();
    write_reg(REG_TOLERANCE, 16'd0);
    write_reg(REG_DEPTH_LIMIT, 16'd7);
    send_curve(mk(FUNC_CUBIC, 0, 0, 2560, 5120, 7680, 5120, 10240, 0));
    send_curve(mk(FUNC_CUBIC, 0, 0, 256, 256, 512, 512, 768, 768));
    send_curve(mk(FUNC_QUAD, MINC, MAXC, 0, MINC, 0, 0, MAXC, MAXC));
    drain();
    write_reg(REG_DEPTH_LIMIT, 16'd0);
    write_reg(REG_TOLERANCE, 16'hFFFF);
    send_curve(mk(FUNC_CUBIC, MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC));
    send_curve(mk(FUNC_QUAD, 5, 6, 7, 8, 0, 0, 9, 10));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 65; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 65; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case (ph)
        0: begin write_reg(REG_TOLERANCE, 16'd64); write_reg(REG_DEPTH_LIMIT, 16'd6); end
        1: begin write_reg(REG_TOLERANCE, 16'd8); write_reg(REG_DEPTH_LIMIT, 16'd3); end
        2: begin write_reg(REG_TOLERANCE, 16'd0); write_reg(REG_DEPTH_LIMIT, 16'd2); end
        3: begin write_reg(REG_TOLERANCE, 16'd1000); write_reg(REG_DEPTH_LIMIT, 16'd5); end
        4: begin write_reg(REG_TOLERANCE, 16'hFFFF); write_reg(REG_DEPTH_LIMIT, 16'd1); end
        default: begin
          write_reg(REG_TOLERANCE, 16'($urandom_range(300)));
          write_reg(REG_DEPTH_LIMIT, 16'($urandom_range(7)));
        end
      endcase
      for (int k = 0; k < 20; k++) begin
        send_curve(rand_curve());
        // Let the block run dry once, mid-way through phase 1.
        if (k == 10 && ph == 1) while (board.pending_points.size() != 0) @(posedge clk);
      end
      drain();
    end

    if (board.failures == 0 && board.pending_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
